### hw/rtl/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants for the start code bit scanner.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 20;
  localparam int FIFO_DEPTH      = 4;

  localparam int BYTE_BITS  = 8;
  localparam int WIN_BITS   = 20;
  localparam int HIST_BITS  = 19;
  localparam int JOIN_BITS  = HIST_BITS + BYTE_BITS;
  localparam int OUT_OFF_W  = 32;
  localparam int OUT_BIT_W  = 3;
  localparam int OUT_IDX_W  = 20;
  localparam int OUT_DATA_W = 56;

  localparam logic [WIN_BITS-1:0] START_CODE = 20'h00010;

  // first window position whose start lies in the byte two back
  localparam logic [2:0] POS_SPLIT = 3'd3;
  // bit position of window k is (k + POS_ADJ) mod 8
  localparam logic [2:0] POS_ADJ   = 3'd5;

  typedef struct packed {
    logic       hit;
    logic       last;
    logic [2:0] pos;
  } scb_tag_t;

  localparam int TAG_BITS = $bits(scb_tag_t);

endpackage

### hw/rtl/scb_front.sv
// ----------------------------------------------------------------------------
// scb_front
// Byte intake: keeps the bit history and byte count, checks the eight
// windows ending in each byte and queues hits and end-of-stream marks.
// ----------------------------------------------------------------------------
module scb_front #(
  parameter int OFFSET_BITS = scb_pkg::OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data,
  input  logic                     in_last,
  input  logic                     fifo_full,
  output logic                     push,
  output logic [OFFSET_BITS-1:0]   push_bs,
  output scb_pkg::scb_tag_t        push_tag
);
  import scb_pkg::*;

  localparam logic [OFFSET_BITS-1:0] BS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] BS_TWO = OFFSET_BITS'(2);

  logic [HIST_BITS-1:0]   hist_r, hist_nxt;
  logic [OFFSET_BITS-1:0] bs_r, bs_nxt;
  logic [JOIN_BITS-1:0]   joined;
  logic [WIN_BITS-1:0]    win [BYTE_BITS];
  logic                   ge3, eq2, acc, hit;
  logic [2:0]             pos;

  assign in_ready = !fifo_full;
  assign acc      = in_valid && in_ready;
  assign joined   = {hist_r, in_data};
  assign eq2      = (bs_r == BS_TWO);
  assign ge3      = (bs_r > BS_TWO);

  always_comb begin
    for (int k = 0; k < BYTE_BITS; k++) begin
      win[k] = joined[JOIN_BITS-1-k -: WIN_BITS];
    end
  end

  // lowest position wins
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int k = BYTE_BITS - 1; k >= 0; k--) begin
      if (win[k] == START_CODE && (ge3 || (eq2 && 3'(k) >= POS_SPLIT))) begin
        hit = 1'b1;
        pos = 3'(k);
      end
    end
  end

  always_comb begin
    hist_nxt = hist_r;
    bs_nxt   = bs_r;
    if (acc) begin
      if (in_last) begin
        hist_nxt = '0;
        bs_nxt   = '0;
      end else begin
        hist_nxt = joined[HIST_BITS-1:0];
        if (bs_r != BS_MAX) begin
          bs_nxt = bs_r + OFFSET_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      bs_r   <= '0;
    end else begin
      hist_r <= hist_nxt;
      bs_r   <= bs_nxt;
    end
  end

  assign push          = acc && (hit || in_last);
  assign push_bs       = bs_r;
  assign push_tag.hit  = hit;
  assign push_tag.last = in_last;
  assign push_tag.pos  = pos;

  a_hit_after_two_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && hit) |-> (bs_r >= BS_TWO))
    else $error("hit reported before enough bits arrived");

endmodule

### hw/rtl/scb_fifo.sv
// ----------------------------------------------------------------------------
// scb_fifo
// Small register queue between intake and result stage.
// ----------------------------------------------------------------------------
module scb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = scb_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);
  import scb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

### hw/rtl/scb_back.sv
// ----------------------------------------------------------------------------
// scb_back
// Result stage: forms offset, bit and index of each hit, keeps the hit
// count and holds the result word until taken.
// ----------------------------------------------------------------------------
module scb_back #(
  parameter int OFFSET_BITS = scb_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = scb_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_not_empty,
  input  logic [OFFSET_BITS-1:0]               q_bs,
  input  scb_pkg::scb_tag_t                    q_tag,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [scb_pkg::OUT_DATA_W-1:0]       out_data
);
  import scb_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                   vld_r, vld_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [OUT_OFF_W-1:0]   off_r;
  logic [OUT_BIT_W-1:0]   bit_r;
  logic [OUT_IDX_W-1:0]   idx_r;
  logic [OFFSET_BITS-1:0] off_full;
  logic                   load;

  assign pop  = q_not_empty && (!q_tag.hit || !vld_r || out_ready);
  assign load = pop && q_tag.hit;

  assign off_full = (q_tag.pos >= POS_SPLIT) ? q_bs - OFFSET_BITS'(2)
                                             : q_bs - OFFSET_BITS'(3);

  always_comb begin
    vld_nxt = vld_r;
    cnt_nxt = cnt_r;
    if (vld_r && out_ready) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
    if (pop) begin
      if (q_tag.last) begin
        cnt_nxt = '0;
      end else if (q_tag.hit && cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      off_r <= OUT_OFF_W'(off_full);
      bit_r <= q_tag.pos + POS_ADJ;
      idx_r <= OUT_IDX_W'(cnt_r);
    end
  end

  assign out_valid = vld_r;
  assign out_data  = {1'b0, idx_r, bit_r, off_r};

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_tag.last) |=> (cnt_r == '0))
    else $error("hit count not cleared at end of stream");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && vld_r) |-> out_ready)
    else $error("pending result overwritten");

endmodule

### hw/rtl/start_code_bit_scanner_top.sv
// ----------------------------------------------------------------------------
// start_code_bit_scanner_top
// Scans a byte stream for the 20-bit picture start code 0x00010 at every bit
// position and reports where each one begins. Takes one byte per clock
// cycle while the queue is not full, checking the eight windows ending in
// each byte at once; a hit passes through the queue and the output register.
// in_tlast ends the stream and clears history, byte count and hit count.
// A four-word queue sits between intake and the output register, so the
// input keeps running while a result waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module start_code_bit_scanner_top #(
  parameter int OFFSET_BITS = scb_pkg::OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = scb_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // code_byte_offset[31:0], code_bit[34:32], code_index[54:35], zero[55]
  output logic [scb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import scb_pkg::*;

  localparam int Q_WIDTH = OFFSET_BITS + TAG_BITS;

  logic                   push, full, pop, not_empty;
  logic [OFFSET_BITS-1:0] push_bs, q_bs;
  scb_tag_t               push_tag, q_tag;
  logic [Q_WIDTH-1:0]     q_rd;

  scb_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .fifo_full (full),
    .push      (push),
    .push_bs   (push_bs),
    .push_tag  (push_tag)
  );

  scb_fifo #(
    .WIDTH(Q_WIDTH),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   ({push_bs, push_tag}),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_data   (q_rd)
  );

  assign q_bs  = q_rd[Q_WIDTH-1:TAG_BITS];
  assign q_tag = q_rd[TAG_BITS-1:0];

  scb_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_bs        (q_bs),
    .q_tag       (q_tag),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the start code bit scanner. Byte streams are built bit by
// bit around embedded, overlapping and broken start codes, then driven
// through four traffic phases with random idle and stall cycles. Each hit is
// predicted when its byte is accepted and checked field by field at the
// output.
// ----------------------------------------------------------------------------
module tb_top;
  import scb_pkg::*;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } stream_byte_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_BIT_W-1:0] bitpos;
    logic [OUT_OFF_W-1:0] offset;
  } code_hit_t;

  localparam int          CYCLE_LIMIT     = 300000;
  localparam int          ITEMS_PER_PHASE = 185;
  localparam logic [31:0] OFFSET_SAT      = '1;
  localparam logic [19:0] COUNT_SAT       = '1;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  stream_byte_t byte_q[$];
  code_hit_t    hit_q[$];
  bit           bit_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned cycles         = 0;

  logic [HIST_BITS-1:0] hist        = '0;
  logic [31:0]          bytes_seen  = '0;
  logic [19:0]          codes_found = '0;

  start_code_bit_scanner_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    errors++;
  endtask

  // expected hit, if any, for one accepted byte
  task automatic scan_byte(input logic [7:0] data, input logic last);
    logic [JOIN_BITS-1:0] joined;
    logic [34:0]          end_bit;
    logic [34:0]          start;
    logic                 found;
    code_hit_t            hit;
    joined = {hist, data};
    found  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      end_bit = {bytes_seen, 3'b000} + 35'(k);
      if (!found && end_bit >= 35'd19 &&
          joined[JOIN_BITS-1-k -: WIN_BITS] == START_CODE) begin
        start      = end_bit - 35'd19;
        hit.offset = start[34:3];
        hit.bitpos = start[2:0];
        hit.index  = codes_found;
        hit_q.push_back(hit);
        if (codes_found != COUNT_SAT) codes_found++;
        found = 1'b1;
      end
    end
    hist = joined[HIST_BITS-1:0];
    if (bytes_seen != OFFSET_SAT) bytes_seen++;
    if (last) begin
      hist        = '0;
      bytes_seen  = '0;
      codes_found = '0;
    end
  endtask

  function automatic void put_bits(logic [31:0] value, int width);
    for (int i = width - 1; i >= 0; i--) bit_q.push_back(value[i]);
  endfunction

  function automatic void flush_bytes(bit last);
    stream_byte_t b;
    while (bit_q.size() % 8 != 0) bit_q.push_back(1'($urandom_range(1)));
    while (bit_q.size() > 0) begin
      b.data = '0;
      for (int i = 0; i < 8; i++) b.data = {b.data[6:0], bit_q.pop_front()};
      b.last = last && bit_q.size() == 0;
      byte_q.push_back(b);
    end
  endfunction

  task automatic add_random_stream();
    int unsigned   kind;
    int unsigned   len;
    logic [19:0]   code;
    kind = $urandom_range(9);
    len  = ($urandom_range(7) == 0) ? $urandom_range(48, 20) : $urandom_range(12, 1);
    if (kind <= 6) begin
      while (bit_q.size() < len * 8) begin
        put_bits($urandom, $urandom_range(24));
        code = START_CODE;
        if (kind == 6) code = code ^ (20'd1 << $urandom_range(19));
        // dropping leading zeros lets the code overlap the previous one
        put_bits(code, ($urandom_range(4) == 0) ? $urandom_range(WIN_BITS, 16) : WIN_BITS);
      end
    end else if (kind == 7) begin
      repeat (len) put_bits($urandom, 8);
    end else begin
      repeat (len) put_bits(($urandom_range(3) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00, 8);
    end
    flush_bytes($urandom_range(5) != 0);
  endtask

  always @(posedge clk) begin : drv
    stream_byte_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    code_hit_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hit_q.size() == 0) begin
          report_mismatch("word with no hit pending", out_tdata[31:0], '0);
        end else begin
          want = hit_q.pop_front();
          if (out_tdata[OUT_OFF_W-1:0] !== want.offset)
            report_mismatch("code_byte_offset", out_tdata[OUT_OFF_W-1:0], want.offset);
          if (out_tdata[OUT_OFF_W +: OUT_BIT_W] !== want.bitpos)
            report_mismatch("code_bit", 32'(out_tdata[OUT_OFF_W +: OUT_BIT_W]), 32'(want.bitpos));
          if (out_tdata[OUT_OFF_W+OUT_BIT_W +: OUT_IDX_W] !== want.index)
            report_mismatch("code_index", 32'(out_tdata[OUT_OFF_W+OUT_BIT_W +: OUT_IDX_W]),
                            32'(want.index));
          if (out_tdata[OUT_DATA_W-1] !== 1'b0)
            report_mismatch("pad bit", 32'(out_tdata[OUT_DATA_W-1]), '0);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // no hit may be reported before the stream's first bit
    put_bits(8'h01, 8);
    put_bits(8'h00, 8);
    put_bits(8'hff, 8);
    flush_bytes(1'b1);
    // codes 17 bits apart: one at every bit position
    put_bits(0, 15);
    repeat (8) begin
      put_bits(1, 1);
      put_bits(0, 16);
    end
    flush_bytes(1'b1);
    // window cut off by end of stream
    put_bits(8'h00, 8);
    put_bits(8'h01, 8);
    flush_bytes(1'b1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 8 : 0;
      recv_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 8 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n = n) begin
        n = n - byte_q.size();
        add_random_stream();
        n = n + byte_q.size();
      end
      do @(negedge clk); while (byte_q.size() != 0 || in_tvalid);
      while (hit_q.size() != 0) @(negedge clk);
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### start_code_bit_scanner_top.f
hw/rtl/scb_pkg.sv
hw/rtl/scb_front.sv
hw/rtl/scb_fifo.sv
hw/rtl/scb_back.sv
hw/rtl/start_code_bit_scanner_top.sv
bench/tb_top.sv
